### hdl/sco_pkg.sv
`default_nettype none

package sco_pkg;

  // Which part of the capsule axis lies nearest to the sphere centre
  typedef enum logic [1:0] {
    PART_START    = 2'd0,
    PART_INTERIOR = 2'd1,
    PART_END      = 2'd2
  } part_t;

endpackage

`default_nettype wire

### hdl/sphere_capsule_overlap_test.sv
`default_nettype none

// Sphere/capsule overlap test. Issue one query word per cycle by raising start
// with the eleven in_ fields; busy never rises, so a new word may follow in
// every cycle. Once a word is taken and has passed the stage registers below,
// out_valid is high for one cycle with out_hit and out_nearest_part; results
// leave in issue order and the receiver must take them as they come, since
// nothing holds the pipeline. Each word passes one register per stage: axis
// and offset differences, per-axis products, dot-product sums, choice of the
// nearest part, the partial products of the interior test, their assembly,
// and the wide compare into the output register. One word is taken per clock.
module sphere_capsule_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_sphere_x,
  input  wire logic signed [COORD_BITS-1:0] in_sphere_y,
  input  wire logic signed [COORD_BITS-1:0] in_sphere_z,
  input  wire logic        [COORD_BITS-2:0] in_sphere_radius,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_start_z,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_z,
  input  wire logic        [COORD_BITS-2:0] in_capsule_radius,
  output logic                              out_valid,
  output logic                              out_hit,
  output sco_pkg::part_t                    out_nearest_part
);

  import sco_pkg::*;

  // Width plan
  //   DW : coordinate difference (one bit above a coordinate)
  //   PW : sums of squares / dot product magnitude / r^2
  //   H  : half of PW, operand slice for the partial products
  //   MW : full product of two PW-bit operands
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * CB + 2;
  localparam int H  = PW / 2;
  localparam int MW = 2 * PW;

  // No back-pressure anywhere in the pipe
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic signed [CB-1:0] p_in [3];
  logic signed [CB-1:0] s_in [3];
  logic signed [CB-1:0] e_in [3];

  assign p_in[0] = in_sphere_x;
  assign p_in[1] = in_sphere_y;
  assign p_in[2] = in_sphere_z;
  assign s_in[0] = in_start_x;
  assign s_in[1] = in_start_y;
  assign s_in[2] = in_start_z;
  assign e_in[0] = in_end_x;
  assign e_in[1] = in_end_y;
  assign e_in[2] = in_end_z;

  // ---------------------------------------------------------------------------
  // Stage A: axis d = E - S, offsets w = P - S and q = P - E, radius sum
  // ---------------------------------------------------------------------------
  logic              va_r;
  logic signed [DW-1:0] d_r [3], d_nxt [3];
  logic signed [DW-1:0] w_r [3], w_nxt [3];
  logic signed [DW-1:0] q_r [3], q_nxt [3];
  logic [CB-1:0]     rsum_r, rsum_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = {e_in[i][CB-1], e_in[i]} - {s_in[i][CB-1], s_in[i]};
      w_nxt[i] = {p_in[i][CB-1], p_in[i]} - {s_in[i][CB-1], s_in[i]};
      q_nxt[i] = {p_in[i][CB-1], p_in[i]} - {e_in[i][CB-1], e_in[i]};
    end
    rsum_nxt = {1'b0, in_sphere_radius} + {1'b0, in_capsule_radius};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= accept;
    end
    d_r    <= d_nxt;
    w_r    <= w_nxt;
    q_r    <= q_nxt;
    rsum_r <= rsum_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage B: per-axis products (one multiplier deep)
  // ---------------------------------------------------------------------------
  logic              vb_r;
  logic signed [2*DW-1:0] dd_r [3], dd_nxt [3];
  logic signed [2*DW-1:0] dw_r [3], dw_nxt [3];
  logic signed [2*DW-1:0] ww_r [3], ww_nxt [3];
  logic signed [2*DW-1:0] qq_r [3], qq_nxt [3];
  logic [2*CB-1:0]   r2b_r, r2b_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_nxt[i] = d_r[i] * d_r[i];
      dw_nxt[i] = d_r[i] * w_r[i];
      ww_nxt[i] = w_r[i] * w_r[i];
      qq_nxt[i] = q_r[i] * q_r[i];
    end
    r2b_nxt = rsum_r * rsum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    dd_r  <= dd_nxt;
    dw_r  <= dw_nxt;
    ww_r  <= ww_nxt;
    qq_r  <= qq_nxt;
    r2b_r <= r2b_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage C: dot products. Squares are below 2^(2*CB), so the low bits suffice.
  // ---------------------------------------------------------------------------
  logic              vc_r;
  logic signed [PW:0] t_r, t_nxt;
  logic [PW-1:0]     len2_r, len2_nxt;
  logic [PW-1:0]     w2_r, w2_nxt;
  logic [PW-1:0]     q2_r, q2_nxt;
  logic [2*CB-1:0]   r2c_r;

  always_comb begin
    t_nxt    = {dw_r[0][PW-1], dw_r[0]} + {dw_r[1][PW-1], dw_r[1]}
             + {dw_r[2][PW-1], dw_r[2]};
    len2_nxt = {2'b00, dd_r[0][2*CB-1:0]} + {2'b00, dd_r[1][2*CB-1:0]}
             + {2'b00, dd_r[2][2*CB-1:0]};
    w2_nxt   = {2'b00, ww_r[0][2*CB-1:0]} + {2'b00, ww_r[1][2*CB-1:0]}
             + {2'b00, ww_r[2][2*CB-1:0]};
    q2_nxt   = {2'b00, qq_r[0][2*CB-1:0]} + {2'b00, qq_r[1][2*CB-1:0]}
             + {2'b00, qq_r[2][2*CB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    t_r    <= t_nxt;
    len2_r <= len2_nxt;
    w2_r   <= w2_nxt;
    q2_r   <= q2_nxt;
    r2c_r  <= r2b_r;
  end

  // ---------------------------------------------------------------------------
  // Stage D: pick the nearest part. Interior test
  //   w2*L < r2*L + t^2  <=>  (w2 - r2)*L < t^2
  // is settled here when w2 < r2 (t > 0 there), else left to the multipliers.
  // ---------------------------------------------------------------------------
  logic              vd_r;
  part_t             part_d_r, part_d_nxt;
  logic              known_d_r, known_d_nxt;   // hit where no product is needed
  logic              need_d_r, need_d_nxt;     // hit comes from the wide compare
  logic [PW-1:0]     diff_r, diff_nxt;
  logic [PW-1:0]     len2_d_r;
  logic [PW-1:0]     tm_r, tm_nxt;

  logic              t_pos;
  logic              w_in;
  logic              q_in;

  always_comb begin
    t_pos       = !t_r[PW] && (t_r != '0);
    w_in        = w2_r < {2'b00, r2c_r};
    q_in        = q2_r < {2'b00, r2c_r};
    diff_nxt    = w2_r - {2'b00, r2c_r};
    tm_nxt      = t_r[PW-1:0];
    part_d_nxt  = PART_INTERIOR;
    known_d_nxt = w_in;
    need_d_nxt  = 1'b0;
    if ((len2_r == '0) || !t_pos) begin
      part_d_nxt  = PART_START;
      known_d_nxt = w_in;
    end else if (t_r[PW-1:0] > len2_r) begin
      part_d_nxt  = PART_END;
      known_d_nxt = q_in;
    end else begin
      part_d_nxt  = PART_INTERIOR;
      known_d_nxt = w_in;
      need_d_nxt  = !w_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    part_d_r  <= part_d_nxt;
    known_d_r <= known_d_nxt;
    need_d_r  <= need_d_nxt;
    diff_r    <= diff_nxt;
    len2_d_r  <= len2_r;
    tm_r      <= tm_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage E: H x H partial products of diff*L and t*t
  // ---------------------------------------------------------------------------
  logic              ve_r;
  part_t             part_e_r;
  logic              known_e_r;
  logic              need_e_r;
  logic [2*H-1:0]    a_ll_r, a_ll_nxt, a_lh_r, a_lh_nxt;
  logic [2*H-1:0]    a_hl_r, a_hl_nxt, a_hh_r, a_hh_nxt;
  logic [2*H-1:0]    b_ll_r, b_ll_nxt, b_lh_r, b_lh_nxt, b_hh_r, b_hh_nxt;

  always_comb begin
    a_ll_nxt = diff_r[H-1:0]  * len2_d_r[H-1:0];
    a_lh_nxt = diff_r[H-1:0]  * len2_d_r[PW-1:H];
    a_hl_nxt = diff_r[PW-1:H] * len2_d_r[H-1:0];
    a_hh_nxt = diff_r[PW-1:H] * len2_d_r[PW-1:H];
    b_ll_nxt = tm_r[H-1:0]    * tm_r[H-1:0];
    b_lh_nxt = tm_r[H-1:0]    * tm_r[PW-1:H];
    b_hh_nxt = tm_r[PW-1:H]   * tm_r[PW-1:H];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
    part_e_r  <= part_d_r;
    known_e_r <= known_d_r;
    need_e_r  <= need_d_r;
    a_ll_r    <= a_ll_nxt;
    a_lh_r    <= a_lh_nxt;
    a_hl_r    <= a_hl_nxt;
    a_hh_r    <= a_hh_nxt;
    b_ll_r    <= b_ll_nxt;
    b_lh_r    <= b_lh_nxt;
    b_hh_r    <= b_hh_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage F: assemble the full products (cross term of t*t counted twice)
  // ---------------------------------------------------------------------------
  logic              vf_r;
  part_t             part_f_r;
  logic              known_f_r;
  logic              need_f_r;
  logic [MW-1:0]     lhs_r, lhs_nxt;
  logic [MW-1:0]     rhs_r, rhs_nxt;

  always_comb begin
    lhs_nxt = {a_hh_r, a_ll_r} + (MW'(a_lh_r) << H) + (MW'(a_hl_r) << H);
    rhs_nxt = {b_hh_r, b_ll_r} + (MW'(b_lh_r) << (H + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= ve_r;
    end
    part_f_r  <= part_e_r;
    known_f_r <= known_e_r;
    need_f_r  <= need_e_r;
    lhs_r     <= lhs_nxt;
    rhs_r     <= rhs_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage G: wide compare into the output register
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  logic              out_hit_r, out_hit_nxt;
  part_t             out_part_r;

  always_comb begin
    out_hit_nxt = need_f_r ? (lhs_r < rhs_r) : known_f_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vf_r;
    end
    out_hit_r  <= out_hit_nxt;
    out_part_r <= part_f_r;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_nearest_part = out_part_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("taken word produced no result after seven cycles");

  a_latency_bwd : assert property (@(posedge clk)
    out_valid |-> $past(accept, 7))
    else $error("result without a word taken seven cycles earlier");

  a_cmp_interior : assert property (@(posedge clk) disable iff (!rst_n)
    vf_r && need_f_r |-> part_f_r == PART_INTERIOR)
    else $error("wide compare used outside the axis interior");

endmodule

`default_nettype wire

### tb/sv/sco_overlap_checker.sv
`timescale 1ns / 1ps

// Watches the query and result channels, predicts the overlap of each query
// word taken and compares every result word with the oldest prediction.
module sco_overlap_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_sphere_x,
  input  logic signed [COORD_BITS-1:0] in_sphere_y,
  input  logic signed [COORD_BITS-1:0] in_sphere_z,
  input  logic        [COORD_BITS-2:0] in_sphere_radius,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  input  logic        [COORD_BITS-2:0] in_capsule_radius,
  input  logic                         out_valid,
  input  logic                         out_hit,
  input  sco_pkg::part_t               out_nearest_part,
  output int                           mismatch_count,
  output int                           words_in_flight
);

  import sco_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic  hit;
    part_t part;
  } overlap_t;

  overlap_t expected_overlaps[$];

  // Nearest axis part and strict overlap, all in exact integer terms
  function automatic overlap_t predict_overlap(
    input longint px, input longint py, input longint pz, input longint rs,
    input longint sx, input longint sy, input longint sz,
    input longint ex, input longint ey, input longint ez, input longint rc
  );
    longint     dx, dy, dz, wx, wy, wz, qx, qy, qz;
    longint     proj, len2, w2, q2, rsum, r2;
    logic [127:0] lhs, rhs;
    overlap_t   res;
    dx   = ex - sx;
    dy   = ey - sy;
    dz   = ez - sz;
    wx   = px - sx;
    wy   = py - sy;
    wz   = pz - sz;
    proj = dx * wx + dy * wy + dz * wz;
    len2 = dx * dx + dy * dy + dz * dz;
    w2   = wx * wx + wy * wy + wz * wz;
    rsum = rs + rc;
    r2   = rsum * rsum;
    if (len2 == 0 || proj <= 0) begin
      res.part = PART_START;
      res.hit  = (w2 < r2);
    end else if (proj > len2) begin
      qx = px - ex;
      qy = py - ey;
      qz = pz - ez;
      q2 = qx * qx + qy * qy + qz * qz;
      res.part = PART_END;
      res.hit  = (q2 < r2);
    end else begin
      // foot point: w2 - proj^2/len2 < r2, cross-multiplied by len2
      lhs = 128'(unsigned'(w2)) * 128'(unsigned'(len2));
      rhs = 128'(unsigned'(r2)) * 128'(unsigned'(len2)) +
            128'(unsigned'(proj)) * 128'(unsigned'(proj));
      res.part = PART_INTERIOR;
      res.hit  = (lhs < rhs);
    end
    return res;
  endfunction

  initial begin
    mismatch_count  = 0;
    words_in_flight = 0;
  end

  always @(posedge clk) begin
    overlap_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_overlaps.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected result word hit=%0d part=%0d", $realtime,
                     out_hit, out_nearest_part);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_overlaps.pop_front();
          if (out_hit !== want.hit || out_nearest_part !== want.part) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("%0t: mismatch hit exp %0d got %0d, part exp %0d got %0d",
                       $realtime, want.hit, out_hit, want.part, out_nearest_part);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_overlaps.insert(expected_overlaps.size(), predict_overlap(
          in_sphere_x, in_sphere_y, in_sphere_z, longint'(in_sphere_radius),
          in_start_x, in_start_y, in_start_z,
          in_end_x, in_end_y, in_end_z, longint'(in_capsule_radius)));
    end
    words_in_flight = expected_overlaps.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Top of the sphere/capsule overlap bench. It only produces query words and
// gives the verdict; all prediction and comparison sits in the checker.
module testbench;

  localparam int COORD_BITS     = 16;
  localparam int RANDOM_WORDS   = 800;
  localparam int CALM_TAIL      = 150;   // last words go back to back
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int DRAIN_CYCLES   = 16;    // pipeline is seven deep

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;

  logic signed [COORD_BITS-1:0] in_sphere_x       = '0;
  logic signed [COORD_BITS-1:0] in_sphere_y       = '0;
  logic signed [COORD_BITS-1:0] in_sphere_z       = '0;
  logic        [COORD_BITS-2:0] in_sphere_radius  = '0;
  logic signed [COORD_BITS-1:0] in_start_x        = '0;
  logic signed [COORD_BITS-1:0] in_start_y        = '0;
  logic signed [COORD_BITS-1:0] in_start_z        = '0;
  logic signed [COORD_BITS-1:0] in_end_x          = '0;
  logic signed [COORD_BITS-1:0] in_end_y          = '0;
  logic signed [COORD_BITS-1:0] in_end_z          = '0;
  logic        [COORD_BITS-2:0] in_capsule_radius = '0;

  logic           out_valid;
  logic           out_hit;
  sco_pkg::part_t out_nearest_part;

  int mismatch_count;
  int words_in_flight;
  int idle_cycles = 0;
  bit idling_enabled = 1'b1;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sphere_capsule_overlap_test #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sphere_x      (in_sphere_x),
    .in_sphere_y      (in_sphere_y),
    .in_sphere_z      (in_sphere_z),
    .in_sphere_radius (in_sphere_radius),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_end_z         (in_end_z),
    .in_capsule_radius(in_capsule_radius),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_nearest_part (out_nearest_part)
  );

  sco_overlap_checker #(
    .COORD_BITS(COORD_BITS)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sphere_x      (in_sphere_x),
    .in_sphere_y      (in_sphere_y),
    .in_sphere_z      (in_sphere_z),
    .in_sphere_radius (in_sphere_radius),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_end_z         (in_end_z),
    .in_capsule_radius(in_capsule_radius),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_nearest_part (out_nearest_part),
    .mismatch_count   (mismatch_count),
    .words_in_flight  (words_in_flight)
  );

  // Uniform value in [-half, half]
  function automatic int spread(input int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Coordinate biased towards the corners of the signed range
  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int extreme_radius();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 32767;
      2: return 1;
      default: return int'($urandom_range(0, 32767));
    endcase
  endfunction

  // Present one query word at the falling edge and hold it until taken.
  // Afterwards, when idling is on, start may drop before the next word.
  task automatic send_query(
    input int px, input int py, input int pz, input int rs,
    input int sx, input int sy, input int sz,
    input int ex, input int ey, input int ez, input int rc
  );
    int gap;
    @(negedge clk);
    start             <= 1'b1;
    in_sphere_x       <= px[COORD_BITS-1:0];
    in_sphere_y       <= py[COORD_BITS-1:0];
    in_sphere_z       <= pz[COORD_BITS-1:0];
    in_sphere_radius  <= rs[COORD_BITS-2:0];
    in_start_x        <= sx[COORD_BITS-1:0];
    in_start_y        <= sy[COORD_BITS-1:0];
    in_start_z        <= sz[COORD_BITS-1:0];
    in_end_x          <= ex[COORD_BITS-1:0];
    in_end_y          <= ey[COORD_BITS-1:0];
    in_end_z          <= ez[COORD_BITS-1:0];
    in_capsule_radius <= rc[COORD_BITS-2:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Watchdog: any word moving on either channel restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int bx, by, bz;
    int sx, sy, sz, ex, ey, ez, k;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed words ----
    // Zero-length axis: zero radii only touch, so no hit; radius 1 hits
    send_query(0, 0, 0, 0,  0, 0, 0,  0, 0, 0,  0);
    send_query(0, 0, 0, 1,  0, 0, 0,  0, 0, 0,  0);
    // Zero-length axis, centre at distance 5: radius sum 5 misses, 6 hits
    send_query(3, 4, 0, 2,  0, 0, 0,  0, 0, 0,  3);
    send_query(3, 4, 0, 2,  0, 0, 0,  0, 0, 0,  4);
    // Projection exactly at the start point counts as the start
    send_query(0, 5, 0, 2,  0, 0, 0,  10, 0, 0,  3);
    send_query(0, 5, 0, 2,  0, 0, 0,  10, 0, 0,  4);
    // Projection before the start
    send_query(-3, 4, 0, 5,  0, 0, 0,  10, 0, 0,  0);
    send_query(-3, 4, 0, 5,  0, 0, 0,  10, 0, 0,  1);
    // Projection past the end
    send_query(13, 4, 0, 5,  0, 0, 0,  10, 0, 0,  0);
    send_query(13, 4, 0, 5,  0, 0, 0,  10, 0, 0,  1);
    // Projection exactly at the end is still the interior
    send_query(10, 4, 0, 4,  0, 0, 0,  10, 0, 0,  0);
    send_query(10, 4, 0, 4,  0, 0, 0,  10, 0, 0,  1);
    send_query(10, 0, 0, 0,  0, 0, 0,  10, 0, 0,  0);
    // Plain interior, and a diagonal axis where the foot is off-lattice
    send_query(5, 3, 0, 3,  0, 0, 0,  10, 0, 0,  0);
    send_query(5, 3, 0, 2,  0, 0, 0,  10, 0, 0,  2);
    send_query(1, 2, 0, 1,  0, 0, 0,  3, 3, 3,  0);
    send_query(1, 2, 0, 1,  0, 0, 0,  3, 3, 3,  1);
    // Full-range corners: widest products and largest radius sum
    send_query(32767, -32768, 32767, 32767,  -32768, -32768, -32768,
               32767, 32767, 32767, 32767);
    send_query(-32768, -32768, -32768, 32767,  32767, 32767, 32767,
               32767, 32767, 32767, 32767);
    send_query(0, 32767, 0, 0,  -32768, 0, 0,  32767, 0, 0,  0);
    send_query(0, -32768, -32768, 32767,  32767, 32767, 32767,
               -32768, -32768, -32768, 0);
    send_query(-1, -1, -1, 0,  -32768, -32768, -32768,  32767, 32767, 32767, 1);

    // ---- random words ----
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // idling switches on and off in stretches, and stops for the tail
      if (n >= RANDOM_WORDS - CALM_TAIL)
        idling_enabled = 1'b0;
      else if (n % 50 == 0)
        idling_enabled = ($urandom_range(0, 3) != 0);

      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // anything at all: covers every bit of every field
          send_query(spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     int'($urandom_range(0, 32767)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     spread(32767) - int'($urandom_range(0, 1)),
                     int'($urandom_range(0, 32767)));
        end
        3, 4, 5: begin
          // tight lattice: zero-length axes, t = 0, t = L and touching
          // distances all turn up often
          bx = spread(30000);
          by = spread(30000);
          bz = spread(30000);
          send_query(bx + spread(12), by + spread(12), bz + spread(12),
                     int'($urandom_range(0, 8)),
                     bx + spread(4), by + spread(4), bz + spread(4),
                     bx + spread(4), by + spread(4), bz + spread(4),
                     int'($urandom_range(0, 8)));
        end
        6, 7, 8: begin
          // centre placed along the axis, a little before, inside or past
          bx = spread(28000);
          by = spread(28000);
          bz = spread(28000);
          sx = bx + spread(1000);
          sy = by + spread(1000);
          sz = bz + spread(1000);
          ex = bx + spread(1000);
          ey = by + spread(1000);
          ez = bz + spread(1000);
          k  = int'($urandom_range(0, 12)) - 2;
          send_query(sx + (ex - sx) * k / 8 + spread(200),
                     sy + (ey - sy) * k / 8 + spread(200),
                     sz + (ez - sz) * k / 8 + spread(200),
                     int'($urandom_range(0, 400)),
                     sx, sy, sz, ex, ey, ez,
                     int'($urandom_range(0, 400)));
        end
        default: begin
          send_query(extreme_coord(), extreme_coord(), extreme_coord(),
                     extreme_radius(),
                     extreme_coord(), extreme_coord(), extreme_coord(),
                     extreme_coord(), extreme_coord(), extreme_coord(),
                     extreme_radius());
        end
      endcase
    end

    @(negedge clk);
    start <= 1'b0;

    // All words issued: wait for every prediction to be matched, then let
    // the pipeline run dry so a stray result word would still be caught
    wait (words_in_flight == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
